### rtl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// No dependencies; the bodies expect clk_i and rst_ni in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

### rtl/srtf_pkg.sv
// Package for the SRTF scheduler: opcodes, sequencer states, fixed field widths.
// No dependencies.
package srtf_pkg;

  localparam int unsigned TIME_W  = 21;
  localparam int unsigned ARR_W   = 16;
  localparam int unsigned SLOT_PW = 4;
  localparam int unsigned JCNT_W  = 5;
  localparam int unsigned OP_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2
  } opcode_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_FINISH = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

endpackage

### rtl/srtf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srtf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/srtf_preemptive_scheduler_core.sv
// SRTF scheduler core. Load and restart transactions complete in the cycle they are
// accepted; busy_o stays low. A tick scans n = min(job_count, MAX_JOBS) slots through one
// compare unit, one slot per cycle from the table RAMs; the strobe comes in the cycle
// busy_o falls, when a new one may be taken. A tick after all jobs are done answers the
// next cycle with no busy time. No stalls. Reset (async, low) sets job_count to 1 and
// clears time, done count, fresh bits and sequencer state; payload registers are not reset.
`include "assert_macros.svh"

module srtf_preemptive_scheduler_core #(
  parameter int unsigned MAX_JOBS   = 16,
  parameter int unsigned BURST_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command side
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [srtf_pkg::OP_W-1:0]   opcode_i,
  input  logic [srtf_pkg::SLOT_PW-1:0] slot_i,
  input  logic [srtf_pkg::ARR_W-1:0]  job_arrival_i,
  input  logic [15:0]                 job_burst_i,
  // configuration write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [srtf_pkg::JCNT_W-1:0] cfg_job_count_i,
  // result side, one-cycle strobe
  output logic                        done_o,
  output logic                        idle_o,
  output logic [srtf_pkg::SLOT_PW-1:0] running_slot_o,
  output logic                        finished_o,
  output logic [srtf_pkg::TIME_W-1:0] finish_time_o,
  output logic [srtf_pkg::TIME_W-1:0] turnaround_o,
  output logic [srtf_pkg::TIME_W-1:0] waiting_o,
  output logic                        all_done_o
);

  import srtf_pkg::*;

  localparam int unsigned SLOT_W = $clog2(MAX_JOBS);
  localparam int unsigned CNT_W  = $clog2(MAX_JOBS + 1);
  localparam int unsigned AB_W   = ARR_W + BURST_BITS;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_e                state_q, state_d;
  logic [JCNT_W-1:0]     job_count_q;
  logic [TIME_W-1:0]     time_q, time_d;
  logic [CNT_W-1:0]      done_cnt_q, done_cnt_d;
  // fresh bit: remaining time of that slot equals its burst (set by load/restart)
  logic [MAX_JOBS-1:0]   fresh_q, fresh_d;

  // scan sequencer
  logic [CNT_W-1:0]      rd_idx_q, rd_idx_d;
  logic [SLOT_W-1:0]     cmp_idx_q, cmp_idx_d;
  logic                  cmp_vld_q, cmp_vld_d;

  // best candidate so far
  logic                  found_q, found_d;
  logic [SLOT_W-1:0]     best_slot_q, best_slot_d;
  logic [BURST_BITS-1:0] best_rem_q, best_rem_d;
  logic [ARR_W-1:0]      best_arr_q, best_arr_d;
  logic [BURST_BITS-1:0] best_burst_q, best_burst_d;
  logic [TIME_W-1:0]     tat_q, tat_d;

  // result registers
  logic                  done_q, done_d;
  logic                  idle_q, idle_d;
  logic [SLOT_PW-1:0]    rslot_q, rslot_d;
  logic                  fin_q, fin_d;
  logic [TIME_W-1:0]     ft_q, ft_d;
  logic [TIME_W-1:0]     rtat_q, rtat_d;
  logic [TIME_W-1:0]     wt_q, wt_d;
  logic                  alld_q, alld_d;

  // ---------------------------------------------------------------------------
  // Table RAMs: {arrival, burst} written by loads, remaining written by ticks
  // ---------------------------------------------------------------------------
  logic                  ab_we;
  logic [SLOT_W-1:0]     ab_waddr;
  logic [AB_W-1:0]       ab_rdata;
  logic                  rem_we;
  logic [BURST_BITS-1:0] rem_rdata;
  logic [SLOT_W-1:0]     rd_addr;

  assign rd_addr  = rd_idx_q[SLOT_W-1:0];
  assign ab_waddr = SLOT_W'(slot_i);

  srtf_ram #(
    .WIDTH (AB_W),
    .DEPTH (MAX_JOBS)
  ) u_ab_ram (
    .clk_i   (clk_i),
    .we_i    (ab_we),
    .waddr_i (ab_waddr),
    .wdata_i ({job_arrival_i, BURST_BITS'(job_burst_i)}),
    .raddr_i (rd_addr),
    .rdata_o (ab_rdata)
  );

  srtf_ram #(
    .WIDTH (BURST_BITS),
    .DEPTH (MAX_JOBS)
  ) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (best_slot_q),
    .wdata_i (best_rem_q - BURST_BITS'(1)),
    .raddr_i (rd_addr),
    .rdata_o (rem_rdata)
  );

  // ---------------------------------------------------------------------------
  // Handshakes and effective job count
  // ---------------------------------------------------------------------------
  logic             accept;
  logic [CNT_W-1:0] eff_cnt;
  logic             all_done_now;

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = !busy_o;
  assign accept      = start_i && !busy_o;
  assign eff_cnt     = (32'(job_count_q) > MAX_JOBS) ? CNT_W'(MAX_JOBS)
                                                     : CNT_W'(job_count_q);
  assign all_done_now = (done_cnt_q >= eff_cnt);

  // ---------------------------------------------------------------------------
  // Shared compare unit: one slot per cycle against the best so far.
  // Ties keep the earlier (lower) slot, as only a strictly smaller time wins.
  // ---------------------------------------------------------------------------
  logic [ARR_W-1:0]      cmp_arr;
  logic [BURST_BITS-1:0] cmp_burst;
  logic [BURST_BITS-1:0] cmp_rem;
  logic                  cmp_take;
  logic                  issue;

  assign cmp_arr   = ab_rdata[AB_W-1 -: ARR_W];
  assign cmp_burst = ab_rdata[BURST_BITS-1:0];
  assign cmp_rem   = fresh_q[cmp_idx_q] ? cmp_burst : rem_rdata;
  assign cmp_take  = cmp_vld_q && (TIME_W'(cmp_arr) <= time_q) && (cmp_rem != '0) &&
                     (!found_q || (cmp_rem < best_rem_q));
  assign issue     = (rd_idx_q < eff_cnt);

  assign rem_we = (state_q == ST_UPDATE) && found_q;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    time_d       = time_q;
    done_cnt_d   = done_cnt_q;
    fresh_d      = fresh_q;
    rd_idx_d     = rd_idx_q;
    cmp_idx_d    = cmp_idx_q;
    cmp_vld_d    = 1'b0;
    found_d      = found_q;
    best_slot_d  = best_slot_q;
    best_rem_d   = best_rem_q;
    best_arr_d   = best_arr_q;
    best_burst_d = best_burst_q;
    tat_d        = tat_q;
    ab_we        = 1'b0;

    done_d  = 1'b0;
    idle_d  = idle_q;
    rslot_d = rslot_q;
    fin_d   = fin_q;
    ft_d    = ft_q;
    rtat_d  = rtat_q;
    wt_d    = wt_q;
    alld_d  = alld_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_LOAD) begin
            if (32'(slot_i) < MAX_JOBS) begin
              ab_we             = 1'b1;
              fresh_d[ab_waddr] = 1'b1;
            end
          end else if (opcode_i == OP_RESTART) begin
            time_d     = '0;
            done_cnt_d = '0;
            fresh_d    = '1;
          end else if (opcode_i == OP_TICK) begin
            if (all_done_now) begin
              // nothing left: answer at once, time holds
              done_d  = 1'b1;
              idle_d  = 1'b1;
              rslot_d = '0;
              fin_d   = 1'b0;
              ft_d    = '0;
              rtat_d  = '0;
              wt_d    = '0;
              alld_d  = 1'b1;
            end else begin
              rd_idx_d = '0;
              found_d  = 1'b0;
              state_d  = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        if (cmp_take) begin
          found_d      = 1'b1;
          best_slot_d  = cmp_idx_q;
          best_rem_d   = cmp_rem;
          best_arr_d   = cmp_arr;
          best_burst_d = cmp_burst;
        end
        if (issue) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_addr;
          rd_idx_d  = rd_idx_q + CNT_W'(1);
        end else begin
          // last compare lands this cycle
          state_d = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        time_d = time_q + TIME_W'(1);
        if (found_q) begin
          fresh_d[best_slot_q] = 1'b0;
        end
        if (found_q && (best_rem_q == BURST_BITS'(1))) begin
          done_cnt_d = done_cnt_q + CNT_W'(1);
          state_d    = ST_FINISH;
        end else begin
          done_d  = 1'b1;
          idle_d  = !found_q;
          rslot_d = found_q ? SLOT_PW'(best_slot_q) : '0;
          fin_d   = 1'b0;
          ft_d    = '0;
          rtat_d  = '0;
          wt_d    = '0;
          alld_d  = all_done_now;
          state_d = ST_IDLE;
        end
      end

      ST_FINISH: begin
        tat_d   = time_q - TIME_W'(best_arr_q);
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        done_d  = 1'b1;
        idle_d  = 1'b0;
        rslot_d = SLOT_PW'(best_slot_q);
        fin_d   = 1'b1;
        ft_d    = time_q;
        rtat_d  = tat_q;
        wt_d    = tat_q - TIME_W'(best_burst_q);
        alld_d  = all_done_now;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_count_q <= JCNT_W'(1);
      time_q      <= '0;
      done_cnt_q  <= '0;
      fresh_q     <= '0;
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      time_q     <= time_d;
      done_cnt_q <= done_cnt_d;
      fresh_q    <= fresh_d;
      rd_idx_q   <= rd_idx_d;
      cmp_vld_q  <= cmp_vld_d;
      found_q    <= found_d;
      done_q     <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        job_count_q <= cfg_job_count_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q    <= cmp_idx_d;
    best_slot_q  <= best_slot_d;
    best_rem_q   <= best_rem_d;
    best_arr_q   <= best_arr_d;
    best_burst_q <= best_burst_d;
    tat_q        <= tat_d;
    idle_q       <= idle_d;
    rslot_q      <= rslot_d;
    fin_q        <= fin_d;
    ft_q         <= ft_d;
    rtat_q       <= rtat_d;
    wt_q         <= wt_d;
    alld_q       <= alld_d;
  end

  assign done_o         = done_q;
  assign idle_o         = idle_q;
  assign running_slot_o = rslot_q;
  assign finished_o     = fin_q;
  assign finish_time_o  = ft_q;
  assign turnaround_o   = rtat_q;
  assign waiting_o      = wt_q;
  assign all_done_o     = alld_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_PROP(a_scan_bound, (state_q == ST_SCAN) |-> (rd_idx_q <= eff_cnt), "scan past count")
  `ASSERT_PROP(a_update_next, (state_q == ST_UPDATE) |=> (done_q || state_q == ST_FINISH), "no exit")
  `ASSERT_PROP(a_finish_found, (state_q == ST_FINISH) |-> found_q, "finish without a job")
  `ASSERT_PROP(a_load_nobusy, (accept && (opcode_i == OP_LOAD)) |=> !busy_o, "load raised busy")
  `ASSERT_NEVER(a_fin_idle, done_o && finished_o && idle_o, "finished flag on an idle result")

endmodule
